### rtl/assert_macros.svh
// Assertion macros used by the slot table back end.
// Depends on nothing; users must provide clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define GHST_ASSERT_RUN(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");
`define GHST_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");
`else
`define GHST_ASSERT_RUN(label, prop)
`define GHST_ASSERT_RST(label, prop)
`endif
`endif

### rtl/ghst_pkg.sv
// Package for the generational handle slot table: word types, codes and sizes.
// Depends on nothing.
package ghst_pkg;

  localparam int SLOTS_DEFAULT = 64;
  localparam int SLOT_FIELD_W  = 16;
  localparam int GEN_W         = 12;
  localparam int GROUP_SIZE    = 8;

  localparam logic [GEN_W-1:0] GEN_FIRST = 12'd1;
  localparam logic [GEN_W-1:0] GEN_LAST  = 12'hFFF;

  localparam logic [1:0] OP_CREATE  = 2'd0;
  localparam logic [1:0] OP_RESOLVE = 2'd1;
  localparam logic [1:0] OP_DESTROY = 2'd2;
  localparam logic [1:0] OP_CLEAR   = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_BACKEND = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] handle_in;
    logic [31:0] object_id;
    logic        object_ok;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [27:0] handle_out;
    logic [31:0] object_out;
  } out_word_t;

  typedef enum logic [1:0] {
    CMD_CREATE,
    CMD_LOOKUP,
    CMD_CLEAR,
    CMD_REJECT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t               kind;
    logic                    is_destroy;
    logic [SLOT_FIELD_W-1:0] slot_idx;
    logic [GEN_W-1:0]        gen;
    logic [31:0]             object_id;
    logic                    object_ok;
  } cmd_t;

endpackage

### rtl/ghst_front.sv
// Front end: decodes an input word and checks the static fields of its handle.
// Depends on ghst_pkg.
module ghst_front #(
  parameter int SLOTS = ghst_pkg::SLOTS_DEFAULT
) (
  input  ghst_pkg::in_word_t in_word,
  output ghst_pkg::cmd_t     cmd
);

  logic [ghst_pkg::SLOT_FIELD_W-1:0] slot_field;
  logic [ghst_pkg::GEN_W-1:0]        gen_field;
  logic [ghst_pkg::SLOT_FIELD_W:0]   slot_idx_ext;
  logic                              bad_handle;

  assign slot_field   = in_word.handle_in[15:0];
  assign gen_field    = in_word.handle_in[27:16];
  assign slot_idx_ext = {1'b0, slot_field} - 17'd1;
  assign bad_handle   = (slot_field == '0) || (gen_field == '0) ||
                        (slot_idx_ext >= 17'(SLOTS));

  always_comb begin
    cmd.is_destroy = (in_word.opcode == ghst_pkg::OP_DESTROY);
    cmd.slot_idx   = slot_idx_ext[ghst_pkg::SLOT_FIELD_W-1:0];
    cmd.gen        = gen_field;
    cmd.object_id  = in_word.object_id;
    cmd.object_ok  = in_word.object_ok;
    case (in_word.opcode)
      ghst_pkg::OP_CREATE: begin
        cmd.kind = ghst_pkg::CMD_CREATE;
      end
      ghst_pkg::OP_RESOLVE, ghst_pkg::OP_DESTROY: begin
        cmd.kind = bad_handle ? ghst_pkg::CMD_REJECT : ghst_pkg::CMD_LOOKUP;
      end
      default: begin
        cmd.kind = ghst_pkg::CMD_CLEAR;
      end
    endcase
  end

endmodule

### rtl/ghst_queue.sv
// Two-entry queue of decoded commands between the front and back ends.
// Depends on ghst_pkg.
module ghst_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_stall,
  input  ghst_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop,
  output ghst_pkg::cmd_t pop_cmd
);

  ghst_pkg::cmd_t entry_r [2];
  logic           wr_ptr_r;
  logic           rd_ptr_r;
  logic [1:0]     count_r;
  logic           push_fire;
  logic           pop_fire;

  assign push_stall = (count_r == 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_cmd    = entry_r[rd_ptr_r];
  assign push_fire  = push_valid && !push_stall;
  assign pop_fire   = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push_fire) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop_fire) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      case ({push_fire, pop_fire})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

### rtl/ghst_back.sv
// Back end: slot search, slot memories, read-modify-write and the result register.
// Depends on ghst_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ghst_back #(
  parameter int SLOTS = ghst_pkg::SLOTS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_pop,
  input  ghst_pkg::cmd_t      q_cmd,
  output logic                out_valid,
  input  logic                out_stall,
  output ghst_pkg::out_word_t out_word
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int NG    = (SLOTS + ghst_pkg::GROUP_SIZE - 1) / ghst_pkg::GROUP_SIZE;
  localparam int GRP_W = (NG > 1) ? $clog2(NG) : 1;
  localparam int BIT_W = $clog2(ghst_pkg::GROUP_SIZE);
  localparam int PAD   = NG * ghst_pkg::GROUP_SIZE;

  typedef enum logic [1:0] {
    S_IDLE,
    S_GROUP,
    S_PICK,
    S_EXEC
  } state_t;

  state_t                     state_r;
  state_t                     state_nxt;
  ghst_pkg::cmd_t             cmd_r;
  logic [IDX_W-1:0]           idx_r;
  logic [GRP_W-1:0]           grp_r;
  logic                       full_r;
  logic [SLOTS-1:0]           active_r;
  logic [SLOTS-1:0]           gval_r;
  logic                       act_rd_r;
  logic                       gval_rd_r;
  logic [ghst_pkg::GEN_W-1:0] gen_rd_r;
  logic [31:0]                obj_rd_r;
  logic                       out_valid_r;
  ghst_pkg::out_word_t        out_word_r;

  logic [ghst_pkg::GEN_W-1:0] gen_mem [SLOTS];
  logic [31:0]                obj_mem [SLOTS];

  logic [PAD-1:0]                  busy_pad;
  logic                            grp_found;
  logic [GRP_W-1:0]                grp_sel;
  logic [ghst_pkg::GROUP_SIZE-1:0] grp_bits;
  logic [BIT_W-1:0]                bit_sel;
  logic [GRP_W+BIT_W-1:0]          pick_wide;
  logic [IDX_W-1:0]                pick_idx;
  logic [IDX_W-1:0]                rd_addr;
  logic                            rd_en;
  logic                            out_free;
  logic                            exec_fire;
  logic [ghst_pkg::GEN_W-1:0]      gen_cur;
  logic [ghst_pkg::GEN_W-1:0]      gen_adv;
  logic                            live;
  logic                            is_create;
  logic                            is_clear;
  logic                            create_ok;
  logic                            destroy_ok;
  ghst_pkg::out_word_t             res;

  always_comb begin
    busy_pad           = '1;
    busy_pad[SLOTS-1:0] = active_r;
  end

  always_comb begin
    grp_found = 1'b0;
    grp_sel   = '0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (!(&busy_pad[g*ghst_pkg::GROUP_SIZE +: ghst_pkg::GROUP_SIZE])) begin
        grp_found = 1'b1;
        grp_sel   = GRP_W'(g);
      end
    end
  end

  assign grp_bits = busy_pad[int'(grp_r)*ghst_pkg::GROUP_SIZE +: ghst_pkg::GROUP_SIZE];

  always_comb begin
    bit_sel = '0;
    for (int b = ghst_pkg::GROUP_SIZE - 1; b >= 0; b--) begin
      if (!grp_bits[b]) begin
        bit_sel = BIT_W'(b);
      end
    end
  end

  assign pick_wide = {grp_r, bit_sel};
  assign pick_idx  = IDX_W'(pick_wide);
  assign rd_addr   = (state_r == S_PICK) ? pick_idx : q_cmd.slot_idx[IDX_W-1:0];
  assign rd_en     = (state_r == S_PICK) ||
                     ((state_r == S_IDLE) && q_valid && (q_cmd.kind == ghst_pkg::CMD_LOOKUP));
  assign q_pop     = (state_r == S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign exec_fire = (state_r == S_EXEC) && out_free;

  assign gen_cur    = gval_rd_r ? gen_rd_r : ghst_pkg::GEN_FIRST;
  assign gen_adv    = (gen_cur == ghst_pkg::GEN_LAST) ? ghst_pkg::GEN_FIRST :
                      gen_cur + 12'd1;
  assign live       = act_rd_r && (gen_cur == cmd_r.gen);
  assign is_create  = (cmd_r.kind == ghst_pkg::CMD_CREATE);
  assign is_clear   = (cmd_r.kind == ghst_pkg::CMD_CLEAR);
  assign create_ok  = is_create && !full_r && cmd_r.object_ok;
  assign destroy_ok = (cmd_r.kind == ghst_pkg::CMD_LOOKUP) && cmd_r.is_destroy && live;

  always_comb begin
    res = '0;
    case (cmd_r.kind)
      ghst_pkg::CMD_CREATE: begin
        if (full_r) begin
          res.status = ghst_pkg::ST_FULL;
        end else if (!cmd_r.object_ok) begin
          res.status = ghst_pkg::ST_BACKEND;
        end else begin
          res.status     = ghst_pkg::ST_OK;
          res.handle_out = {gen_cur, ghst_pkg::SLOT_FIELD_W'(idx_r) + 16'd1};
        end
      end
      ghst_pkg::CMD_LOOKUP: begin
        if (live) begin
          res.status     = ghst_pkg::ST_OK;
          res.object_out = obj_rd_r;
        end else begin
          res.status = ghst_pkg::ST_INVALID;
        end
      end
      ghst_pkg::CMD_CLEAR: begin
        res.status = ghst_pkg::ST_OK;
      end
      default: begin
        res.status = ghst_pkg::ST_INVALID;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          state_nxt = (q_cmd.kind == ghst_pkg::CMD_CREATE) ? S_GROUP : S_EXEC;
        end
      end
      S_GROUP: begin
        state_nxt = grp_found ? S_PICK : S_EXEC;
      end
      S_PICK: begin
        state_nxt = S_EXEC;
      end
      default: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= '0;
      gval_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == S_IDLE) && q_valid) begin
        cmd_r <= q_cmd;
        idx_r <= q_cmd.slot_idx[IDX_W-1:0];
      end
      if (state_r == S_GROUP) begin
        grp_r  <= grp_sel;
        full_r <= !grp_found;
      end
      if (state_r == S_PICK) begin
        idx_r <= pick_idx;
      end
      if (rd_en) begin
        act_rd_r  <= active_r[rd_addr];
        gval_rd_r <= gval_r[rd_addr];
      end
      if (exec_fire) begin
        out_valid_r <= 1'b1;
        out_word_r  <= res;
        if (create_ok) begin
          active_r[idx_r] <= 1'b1;
        end
        if (destroy_ok) begin
          active_r[idx_r] <= 1'b0;
          gval_r[idx_r]   <= 1'b1;
        end
        if (is_clear) begin
          active_r <= '0;
          gval_r   <= '0;
        end
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      gen_rd_r <= gen_mem[rd_addr];
      obj_rd_r <= obj_mem[rd_addr];
    end
    if (exec_fire && create_ok) begin
      obj_mem[idx_r] <= cmd_r.object_id;
    end
    if (exec_fire && destroy_ok) begin
      gen_mem[idx_r] <= gen_adv;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `GHST_ASSERT_RUN(a_full_only_when_all_busy, (exec_fire && is_create && full_r) |-> (&busy_pad))
  `GHST_ASSERT_RUN(a_create_takes_free_slot, (exec_fire && is_create && !full_r) |-> !act_rd_r)
  `GHST_ASSERT_RUN(a_destroy_frees_slot, (exec_fire && destroy_ok) |=> !active_r[$past(idx_r)])
  `GHST_ASSERT_RUN(a_clear_empties_table, (exec_fire && is_clear) |=> !(|{active_r, gval_r}))
  `GHST_ASSERT_RST(a_reset_state, !rst_n |=> (active_r == '0 && !out_valid_r && state_r == S_IDLE))

endmodule

### rtl/generational_handle_slot_table_unit.sv
// Top level of the generational handle slot table.
// Depends on ghst_pkg, ghst_front, ghst_queue and ghst_back.
//
//   channel | valid     | stall     | word
//   input   | in_valid  | in_stall  | in_word  (ghst_pkg::in_word_t)
//   result  | out_valid | out_stall | out_word (ghst_pkg::out_word_t)
//
// Each word is decoded on entry and waits in a two-entry command queue.
// The back end goes from idle to execute for resolve, destroy, clear and rejected
// handles; a create visits the group state and, unless the table is full, the pick
// state: the free-slot search looks at groups of eight slots, then at one group's slots.
// Reset clears the active and generation flags directly; there is no clearing pass.
// A waiting result stalls only the back end; the queue keeps taking words until full.
module generational_handle_slot_table_unit #(
  parameter int SLOTS = ghst_pkg::SLOTS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ghst_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output ghst_pkg::out_word_t out_word
);

  ghst_pkg::cmd_t front_cmd;
  ghst_pkg::cmd_t q_cmd;
  logic           q_valid;
  logic           q_pop;

  ghst_front #(
    .SLOTS(SLOTS)
  ) u_front (
    .in_word(in_word),
    .cmd    (front_cmd)
  );

  ghst_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(in_valid),
    .push_stall(in_stall),
    .push_cmd  (front_cmd),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_cmd   (q_cmd)
  );

  ghst_back #(
    .SLOTS(SLOTS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_cmd    (q_cmd),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

endmodule
